// File: rtl/core/ntwa_pkg.sv
// Package for the node table with aging: table sizes, mode codes,
// transaction payload types and the control bundle passed to each table cell.
// No dependencies.
`timescale 1ns / 1ps

package ntwa_pkg;

  localparam int MAX_NODES = 4;
  localparam int ADDR_W    = 16;
  localparam int AGE_W     = 8;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  localparam logic [AGE_W-1:0] AGE_MAX         = {AGE_W{1'b1}};
  localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = AGE_W'(15);

  // Item mode codes
  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_REFRESH  = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] node_addr;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic       inserted;
    logic       dropped;
    logic [2:0] removed_count;
    logic [2:0] entry_count;
  } out_item_t;

  // Operation broadcast to every cell in the chain
  typedef struct packed {
    logic              lookup;   // register or refresh lookup this cycle
    logic              age;      // increment ages and flag expiry
    logic              shift;    // close the gap at the first expired entry
    logic [ADDR_W-1:0] key;
    logic [AGE_W-1:0]  limit;
  } cell_ctrl_t;

  // Map a table count onto the 3-bit result field (masked)
  function automatic logic [2:0] to_cnt3(logic [CNT_W-1:0] c);
    logic [CNT_W+2:0] tmp;
    tmp = {3'b000, c};
    return tmp[2:0];
  endfunction

endpackage

// File: rtl/core/node_table_with_aging.sv
// Top level of the node table with aging: sequencer, entry count, age limit
// register, output register and the chain of ntwa_cell entries.
// Depends on ntwa_pkg and ntwa_cell.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_stall_o    in_data_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i  out_data_o (out_item_t)
//   cfg       input      cfg_we_i                   cfg_wdata_i (age limit)
//
// Register, refresh and unused-mode transactions: the lookup and insert
// happen in the cells at the accept edge, then ST_OUT moves the result.
// A tick ages the entries at the accept edge; in ST_SHIFT the chain drops one
// expired entry per cycle until it finds no more, then ST_OUT moves the result.
// Reset empties the table at once and sets the age limit to 15.
// A stalled output holds the next result in the sequencer; input stays stalled.
`timescale 1ns / 1ps

module node_table_with_aging import ntwa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [AGE_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_OUT   = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  removed_q, removed_d;
  logic [AGE_W-1:0]  limit_q;
  logic              hit_q, hit_d, ins_q, ins_d, drop_q, drop_d;
  logic              out_valid_q;
  out_item_t         out_data_q;

  logic              accept, is_lookup, is_reg, is_tick, full, hit;
  logic              insert_en, any_exp, out_load;
  cell_ctrl_t        ctrl;

  logic [MAX_NODES-1:0] valid_v, ins_v;
  logic [MAX_NODES:0]   found_c, shift_c;
  logic [ADDR_W-1:0]    addr_c [MAX_NODES+1];
  logic [AGE_W-1:0]     age_c  [MAX_NODES+1];
  logic [MAX_NODES:0]   exp_c;

  // Decode the incoming transaction
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_reg     = (in_data_i.mode == MODE_REGISTER);
  assign is_lookup  = is_reg || (in_data_i.mode == MODE_REFRESH);
  assign is_tick    = (in_data_i.mode == MODE_TICK);
  assign full       = (count_q == CNT_W'(MAX_NODES));

  assign ctrl.lookup = accept && is_lookup;
  assign ctrl.age    = accept && is_tick;
  assign ctrl.shift  = (state_q == ST_SHIFT);
  assign ctrl.key    = in_data_i.node_addr;
  assign ctrl.limit  = limit_q;

  assign hit       = found_c[MAX_NODES];
  assign any_exp   = shift_c[MAX_NODES];
  assign insert_en = ctrl.lookup && is_reg && !hit && !full;

  // Build the chain of table cells
  assign found_c[0]         = 1'b0;
  assign shift_c[0]         = 1'b0;
  assign addr_c[MAX_NODES]  = '0;
  assign age_c[MAX_NODES]   = '0;
  assign exp_c[MAX_NODES]   = 1'b0;

  for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
    assign valid_v[k] = (CNT_W'(k) < count_q);
    assign ins_v[k]   = insert_en && (count_q == CNT_W'(k));

    ntwa_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .valid_i       (valid_v[k]),
      .insert_here_i (ins_v[k]),
      .next_addr_i   (addr_c[k+1]),
      .next_age_i    (age_c[k+1]),
      .next_exp_i    (exp_c[k+1]),
      .found_i       (found_c[k]),
      .found_o       (found_c[k+1]),
      .shift_i       (shift_c[k]),
      .shift_o       (shift_c[k+1]),
      .addr_o        (addr_c[k]),
      .age_o         (age_c[k]),
      .exp_o         (exp_c[k])
    );
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Sequence lookup, compaction and result delivery
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    removed_d = removed_q;
    hit_d     = hit_q;
    ins_d     = ins_q;
    drop_d    = drop_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          hit_d     = ctrl.lookup && hit;
          ins_d     = insert_en;
          drop_d    = ctrl.lookup && is_reg && !hit && full;
          removed_d = '0;
          if (insert_en) begin
            count_d = count_q + CNT_W'(1);
          end
          state_d = is_tick ? ST_SHIFT : ST_OUT;
        end
      end
      ST_SHIFT: begin
        if (any_exp) begin
          count_d   = count_q - CNT_W'(1);
          removed_d = removed_q + CNT_W'(1);
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      limit_q     <= AGE_LIMIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    hit_q     <= hit_d;
    ins_q     <= ins_d;
    drop_q    <= drop_d;
    if (out_load) begin
      out_data_q.hit           <= hit_q;
      out_data_q.inserted      <= ins_q;
      out_data_q.dropped       <= drop_q;
      out_data_q.removed_count <= to_cnt3(removed_q);
      out_data_q.entry_count   <= to_cnt3(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/core/ntwa_cell.sv
// One entry of the node table: address, age and expiry flag, with the
// lookup and compaction chains to its neighbors. Depends on ntwa_pkg.
`timescale 1ns / 1ps

module ntwa_cell import ntwa_pkg::*; (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic                  valid_i,
  input  logic                  insert_here_i,
  input  logic [ADDR_W-1:0]     next_addr_i,
  input  logic [AGE_W-1:0]      next_age_i,
  input  logic                  next_exp_i,
  input  logic                  found_i,
  output logic                  found_o,
  input  logic                  shift_i,
  output logic                  shift_o,
  output logic [ADDR_W-1:0]     addr_o,
  output logic [AGE_W-1:0]      age_o,
  output logic                  exp_o
);

  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [AGE_W-1:0]  age_q, age_d, age_inc;
  logic              exp_q, exp_d;
  logic              match;

  // Lookup chain: first matching valid entry wins
  assign match   = valid_i && (addr_q == ctrl_i.key);
  assign found_o = found_i | match;

  // Compaction chain: this cell and all above the first expired one shift
  assign shift_o = shift_i | (exp_q & valid_i);

  assign age_inc = (age_q == AGE_MAX) ? age_q : age_q + AGE_W'(1);

  // Select next entry contents
  always_comb begin
    addr_d = addr_q;
    age_d  = age_q;
    exp_d  = exp_q;
    if (ctrl_i.lookup) begin
      if (match && !found_i) begin
        age_d = '0;
      end else if (insert_here_i) begin
        addr_d = ctrl_i.key;
        age_d  = '0;
      end
    end else if (ctrl_i.age) begin
      age_d = age_inc;
      exp_d = valid_i && (age_inc > ctrl_i.limit);
    end else if (ctrl_i.shift && shift_o) begin
      addr_d = next_addr_i;
      age_d  = next_age_i;
      exp_d  = next_exp_i;
    end
  end

  // Hold entry payload
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    age_q  <= age_d;
    exp_q  <= exp_d;
  end

  assign addr_o = addr_q;
  assign age_o  = age_q;
  assign exp_o  = exp_q;

endmodule

// File: test/tb_node_table_with_aging.sv
// Self-checking testbench for node_table_with_aging: random bursty stimulus,
// a predictor of the ordered aging table and an in-order result checker.
// Depends on ntwa_pkg and the node_table_with_aging RTL.
`timescale 1ns / 1ps

module tb_node_table_with_aging;
  import ntwa_pkg::*;

  // Unused mode code; the block reports the table size and changes nothing
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [AGE_W-1:0] cfg_wdata_i = '0;

  node_table_with_aging u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Predicted table contents and the age limit in force
  logic [ADDR_W-1:0] tbl_addr [MAX_NODES];
  logic [AGE_W-1:0]  tbl_age  [MAX_NODES];
  int                tbl_count = 0;
  logic [AGE_W-1:0]  tbl_limit = AGE_LIMIT_RESET;

  in_item_t  pending_q [$];
  out_item_t expect_q  [$];
  out_item_t want_res;

  int errors     = 0;
  int sent_count = 0;
  int got_count  = 0;
  int n_hit      = 0;
  int n_ins      = 0;
  int n_drop     = 0;
  int n_expired  = 0;

  // Apply one transaction to the predicted table and return its result
  function automatic out_item_t table_update(in_item_t it);
    out_item_t res;
    int        pos;
    int        i;
    res = '0;
    pos = -1;
    if (it.mode == MODE_REGISTER || it.mode == MODE_REFRESH) begin
      for (i = 0; i < tbl_count; i++) begin
        if (pos < 0 && tbl_addr[i] == it.node_addr) pos = i;
      end
      if (pos >= 0) begin
        res.hit = 1'b1;
        tbl_age[pos] = '0;
      end else if (it.mode == MODE_REGISTER) begin
        if (tbl_count < MAX_NODES) begin
          tbl_addr[tbl_count] = it.node_addr;
          tbl_age[tbl_count]  = '0;
          tbl_count++;
          res.inserted = 1'b1;
        end else begin
          res.dropped = 1'b1;
        end
      end
    end else if (it.mode == MODE_TICK) begin
      // Age every entry; drop expired ones and close the gap in order
      i = 0;
      while (i < tbl_count) begin
        if (tbl_age[i] != AGE_MAX) tbl_age[i] = tbl_age[i] + 1'b1;
        if (tbl_age[i] > tbl_limit) begin
          for (int j = i; j + 1 < tbl_count; j++) begin
            tbl_addr[j] = tbl_addr[j+1];
            tbl_age[j]  = tbl_age[j+1];
          end
          tbl_count--;
          res.removed_count = res.removed_count + 3'd1;
        end else begin
          i++;
        end
      end
    end
    res.entry_count = 3'(tbl_count);
    return res;
  endfunction

  // Driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expect_q.push_back(table_update(in_data_i));
        sent_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall style changes every span; at most twice a long hold-off
  int       span_left   = 0;
  int       stall_style = 0;
  int       hold_left   = 0;
  int       hold_count  = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (pending_q.size() > 30 &&
                 ((hold_count == 0 && got_count >= 300) ||
                  (hold_count == 1 && got_count >= 1200))) begin
      hold_left   <= 120;
      hold_count  <= hold_count + 1;
      out_stall_i <= 1'b1;
    end else begin
      if (span_left == 0) begin
        span_left   <= $urandom_range(16, 96);
        stall_style <= $urandom_range(0, 3);
      end else begin
        span_left <= span_left - 1;
      end
      case (stall_style)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall_i <= ($urandom_range(0, 2) != 0);
        end
        default: begin
          out_stall_i <= ~out_stall_i;
        end
      endcase
    end
  end

  task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 50)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_count++;
      if (expect_q.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
      end else begin
        want_res = expect_q.pop_front();
        check_field("hit", 3'(want_res.hit), 3'(out_data_o.hit));
        check_field("inserted", 3'(want_res.inserted), 3'(out_data_o.inserted));
        check_field("dropped", 3'(want_res.dropped), 3'(out_data_o.dropped));
        check_field("removed_count", want_res.removed_count, out_data_o.removed_count);
        check_field("entry_count", want_res.entry_count, out_data_o.entry_count);
        n_hit     += want_res.hit;
        n_ins     += want_res.inserted;
        n_drop    += want_res.dropped;
        n_expired += want_res.removed_count;
      end
    end
  end

  task automatic add_item(logic [1:0] m, logic [ADDR_W-1:0] a);
    in_item_t it;
    it.mode      = m;
    it.node_addr = a;
    pending_q.push_back(it);
  endtask

  // Queue n random transactions; addresses mostly from a small churning pool when pool_n > 0
  task automatic add_random(int n, int w_reg, int w_ref, int w_odd, int pool_n);
    logic [ADDR_W-1:0] pool [8];
    logic [1:0]        m;
    logic [ADDR_W-1:0] a;
    int                r;
    foreach (pool[k]) pool[k] = ADDR_W'($urandom);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < w_reg) m = MODE_REGISTER;
      else if (r < w_reg + w_ref) m = MODE_REFRESH;
      else if (r < 100 - w_odd) m = MODE_TICK;
      else m = MODE_UNUSED;
      if (pool_n > 0 && $urandom_range(0, 7) != 0) a = pool[$urandom_range(0, pool_n - 1)];
      else a = ADDR_W'($urandom);
      add_item(m, a);
      if (k % 64 == 63) pool[$urandom_range(0, 7)] = ADDR_W'($urandom);
    end
  endtask

  // Hold the sender until every prediction is matched, then let the block settle
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_age_limit(logic [AGE_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tbl_limit = v;
  endtask

  // Main sequence: reset, directed cases, then random phases per age limit
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty-table tick, address extremes, hit, miss, full table, unused mode
    add_item(MODE_TICK,     16'h0000);
    add_item(MODE_REGISTER, 16'h0000);
    add_item(MODE_REGISTER, 16'hFFFF);
    add_item(MODE_REGISTER, 16'h0000);
    add_item(MODE_REFRESH,  16'hFFFF);
    add_item(MODE_REFRESH,  16'h1234);
    add_item(MODE_REGISTER, 16'h5A5A);
    add_item(MODE_REGISTER, 16'hA5A5);
    add_item(MODE_REGISTER, 16'h1111);
    add_item(MODE_REFRESH,  16'h1111);
    add_item(MODE_UNUSED,   16'hFFFF);
    add_item(MODE_UNUSED,   16'h0000);
    add_item(MODE_TICK,     16'hFFFF);
    add_item(MODE_REFRESH,  16'h5A5A);
    add_item(MODE_TICK,     16'h0000);
    wait_drained();

    // Limit zero: a full table expires in one tick
    write_age_limit(8'd0);
    add_item(MODE_TICK,     16'h0000);
    add_item(MODE_REGISTER, 16'hFFFF);
    add_item(MODE_REGISTER, 16'h0000);
    add_item(MODE_TICK,     16'hFFFF);
    wait_drained();

    write_age_limit(8'd1);
    add_random(200, 40, 30, 5, 5);
    wait_drained();

    write_age_limit(AGE_LIMIT_RESET);
    add_random(300, 35, 25, 3, 6);
    wait_drained();

    // Limit 255: fill the table and tick far past saturation
    write_age_limit(8'd255);
    for (int k = 0; k < MAX_NODES; k++) add_item(MODE_REGISTER, ADDR_W'($urandom));
    add_random(350, 4, 1, 2, 0);
    wait_drained();

    // Lowered limit: saturated entries go at the next tick
    write_age_limit(8'd100);
    add_item(MODE_TICK, ADDR_W'($urandom));
    add_random(150, 30, 20, 3, 4);
    wait_drained();

    write_age_limit(8'd254);
    add_random(150, 35, 25, 3, 5);
    wait_drained();

    write_age_limit(8'd0);
    add_random(150, 40, 20, 5, 6);
    wait_drained();

    write_age_limit(8'd2);
    add_random(200, 35, 30, 3, 6);
    wait_drained();

    write_age_limit(AGE_W'($urandom_range(3, 20)));
    add_random(100, 30, 35, 2, 5);
    wait_drained();

    $display("Checked %0d of %0d transactions over age limits 0, 1, 2, 15, 100, 254, 255",
             got_count, sent_count);
    $display("and one random limit: %0d hits, %0d inserts, %0d drops, %0d expiries.",
             n_hit, n_ins, n_drop, n_expired);
    if (errors == 0) begin
      $display("node_table_with_aging verification clean");
    end else begin
      $display("node_table_with_aging verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("node_table_with_aging verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ntwa_pkg.sv
rtl/core/ntwa_cell.sv
rtl/core/node_table_with_aging.sv
test/tb_node_table_with_aging.sv
